// File: rtl/abb_pkg.sv
package abb_pkg;

  // controller -> datapath commands
  typedef struct packed {
    logic load_wr;     // store incoming word
    logic init_clr;    // clear sums before initialization
    logic init_diag;   // accumulate diagonal term (read data valid)
    logic min_first;   // first row of a column minimum
    logic min_step;    // compare a row into the column minimum
    logic min_done;    // commit column minimum and add to bound
    logic try_add;     // add candidate cost / subtract column minimum
    logic try_undo;    // undo candidate
    logic take;        // mark candidate column taken, record it
    logic set_best;    // running cost becomes best
  } abb_cmd_t;

  typedef struct packed {
    logic prune_ok;    // running + remaining < best
  } abb_sts_t;

endpackage

// File: rtl/abb_ram.sv
module abb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// File: rtl/abb_datapath.sv
module abb_datapath #(
  parameter int MAX_SIZE  = 8,
  parameter int COST_BITS = 16,
  parameter int IDX_BITS  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1,
  parameter int SUM_BITS  = COST_BITS + IDX_BITS + 2
) (
  input  logic                   clk,
  input  abb_pkg::abb_cmd_t      cmd,
  output abb_pkg::abb_sts_t      sts,
  input  logic [IDX_BITS-1:0]    wr_row,
  input  logic [IDX_BITS-1:0]    wr_col,
  input  logic [COST_BITS-1:0]   wr_cost,
  input  logic [IDX_BITS-1:0]    rd_row,
  input  logic [IDX_BITS-1:0]    rd_col,
  input  logic [IDX_BITS-1:0]    col,
  input  logic [IDX_BITS-1:0]    lvl,
  output logic [IDX_BITS-1:0]    chosen,
  output logic [SUM_BITS-1:0]    best
);
  import abb_pkg::*;

  localparam int ADDR_BITS = 2 * IDX_BITS;

  logic [COST_BITS-1:0] rd_data;
  logic [COST_BITS-1:0] col_min [MAX_SIZE];
  logic [COST_BITS-1:0] cur_min;
  logic [IDX_BITS-1:0]  chosen_col [MAX_SIZE];
  logic [SUM_BITS-1:0]  running;
  logic [SUM_BITS-1:0]  remaining;

  abb_ram #(.WIDTH(COST_BITS), .DEPTH(1 << ADDR_BITS)) u_cost (
    .clk    (clk),
    .wr_en  (cmd.load_wr),
    .wr_addr({wr_row, wr_col}),
    .wr_data(wr_cost),
    .rd_addr({rd_row, rd_col}),
    .rd_data(rd_data)
  );

  assign sts.prune_ok = (running + remaining) < best;
  assign chosen = chosen_col[lvl];

  always_ff @(posedge clk) begin
    if (cmd.init_clr) begin
      running   <= '0;
      remaining <= '0;
      best      <= '0;
    end
    if (cmd.init_diag) begin
      best <= best + SUM_BITS'(rd_data);
    end
    if (cmd.min_first) begin
      cur_min <= rd_data;
    end else if (cmd.min_step && rd_data < cur_min) begin
      cur_min <= rd_data;
    end
    if (cmd.min_done) begin
      col_min[col] <= cur_min;
      remaining    <= remaining + SUM_BITS'(cur_min);
    end
    if (cmd.try_add) begin
      running   <= running + SUM_BITS'(rd_data);
      remaining <= remaining - SUM_BITS'(col_min[col]);
    end
    if (cmd.try_undo) begin
      running   <= running - SUM_BITS'(rd_data);
      remaining <= remaining + SUM_BITS'(col_min[col]);
    end
    if (cmd.take) begin
      chosen_col[lvl] <= col;
    end
    if (cmd.set_best) begin
      best <= running;
    end
  end
endmodule

// File: rtl/abb_ctrl.sv
module abb_ctrl #(
  parameter int MAX_SIZE = 8,
  parameter int IDX_BITS = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_go,
  input  logic [4:0]          size_n,
  input  abb_pkg::abb_sts_t   sts,
  input  logic [IDX_BITS-1:0] chosen,
  output abb_pkg::abb_cmd_t   cmd,
  output logic [IDX_BITS-1:0] rd_row,
  output logic [IDX_BITS-1:0] rd_col,
  output logic [IDX_BITS-1:0] col,
  output logic [IDX_BITS-1:0] lvl,
  output logic                busy,
  output logic                done
);
  import abb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_DIAG, S_MIN, S_MINW, S_SCAN, S_RD, S_TEST,
    S_BACK, S_POP, S_UNDO, S_DONE
  } state_t;

  state_t               state;
  logic [IDX_BITS:0]    i;          // row counter for init
  logic [IDX_BITS:0]    j;          // column counter
  logic [IDX_BITS:0]    depth;      // current search row
  logic [MAX_SIZE-1:0]  taken;
  logic                 first;

  // j is current candidate column; its cost is at (depth, j)
  always_comb begin
    cmd = '0;
    rd_row = '0;
    rd_col = '0;
    col = j[IDX_BITS-1:0];
    lvl = depth[IDX_BITS-1:0];
    case (state)
      S_DIAG: begin
        rd_row = i[IDX_BITS-1:0];
        rd_col = i[IDX_BITS-1:0];
        cmd.init_diag = !first;
      end
      S_MIN: begin
        // read of row i issued; data of row i-1 compared
        rd_row = i[IDX_BITS-1:0];
        rd_col = j[IDX_BITS-1:0];
        cmd.min_first = (i == (IDX_BITS+1)'(1));
        cmd.min_step  = (i > (IDX_BITS+1)'(1));
      end
      S_MINW: begin
        cmd.min_done = 1'b1;
      end
      S_SCAN: begin
        rd_row = depth[IDX_BITS-1:0];
        rd_col = j[IDX_BITS-1:0];
        // parent level, for backing up
        lvl = depth[IDX_BITS-1:0] - 1'b1;
      end
      S_RD, S_POP: begin
        rd_row = depth[IDX_BITS-1:0];
        rd_col = j[IDX_BITS-1:0];
      end
      S_TEST: begin
        rd_row = depth[IDX_BITS-1:0];
        rd_col = j[IDX_BITS-1:0];
        cmd.try_add = 1'b1;
      end
      S_BACK: begin
        rd_row = depth[IDX_BITS-1:0];
        rd_col = j[IDX_BITS-1:0];
        cmd.take        = sts.prune_ok;
        cmd.set_best    = sts.prune_ok && (depth + 1'b1 == size_n[IDX_BITS:0]);
      end
      S_UNDO: begin
        rd_row = depth[IDX_BITS-1:0];
        rd_col = j[IDX_BITS-1:0];
        cmd.try_undo = 1'b1;
      end
      default: ;
    endcase
    cmd.init_clr = (state == S_CLR);
    cmd.load_wr = 1'b0;
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      taken <= '0;
      i <= '0;
      j <= '0;
      depth <= '0;
      first <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_go) state <= S_CLR;
        S_CLR: begin
          taken <= '0;
          i <= '0;
          first <= 1'b1;
          state <= S_DIAG;
        end
        S_DIAG: begin
          // read of row i issued; data arrives next cycle
          first <= 1'b0;
          if (i == size_n[IDX_BITS:0]) begin
            i <= '0;
            j <= '0;
            state <= S_MIN;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_MIN: begin
          if (i == size_n[IDX_BITS:0]) begin
            state <= S_MINW;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_MINW: begin
          if (j + 1'b1 == size_n[IDX_BITS:0]) begin
            depth <= '0;
            j <= '0;
            state <= S_SCAN;
          end else begin
            j <= j + 1'b1;
            i <= '0;
            state <= S_MIN;
          end
        end
        S_SCAN: begin
          if (j == size_n[IDX_BITS:0]) begin
            // level exhausted: back up
            if (depth == 0) begin
              state <= S_DONE;
            end else begin
              depth <= depth - 1'b1;
              j <= {1'b0, chosen};
              state <= S_POP;
            end
          end else if (taken[j[IDX_BITS-1:0]]) begin
            j <= j + 1'b1;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_TEST;
        S_TEST: state <= S_BACK;
        S_BACK: begin
          if (sts.prune_ok && (depth + 1'b1 != size_n[IDX_BITS:0])) begin
            taken[j[IDX_BITS-1:0]] <= 1'b1;
            depth <= depth + 1'b1;
            j <= '0;
            state <= S_SCAN;
          end else begin
            state <= S_UNDO;
          end
        end
        // re-read the parent's cost before undoing it
        S_POP: state <= S_UNDO;
        S_UNDO: begin
          taken[j[IDX_BITS-1:0]] <= 1'b0;
          j <= j + 1'b1;
          state <= S_SCAN;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/assignment_branch_and_bound_core.sv
// Loading: one word per cycle while in_stall is low. After the last word the search
// clears its sums, adds up the diagonal as the first bound and finds each column's
// minimum, then tries columns row by row, skipping taken ones and backing up when a
// level is exhausted; out_valid rises the cycle after the controller finishes.
// Throughput: one search at a time; in_stall is high from the last word until the
// result is taken. Reset (rst, synchronous): controller idle, matrix_size = 1.
module assignment_branch_and_bound_core #(
  parameter int MAX_SIZE  = 8,
  parameter int COST_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  row,
  input  logic [2:0]  column,
  input  logic [15:0] cost,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [18:0] best_total
);
  import abb_pkg::*;

  localparam int IDX_BITS = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int SUM_BITS = COST_BITS + IDX_BITS + 2;

  logic [3:0]          matrix_size;
  logic [4:0]          size_n;
  abb_cmd_t            cmd_c, cmd;
  abb_sts_t            sts;
  logic [IDX_BITS-1:0] rd_row, rd_col, col, lvl, chosen;
  logic [SUM_BITS-1:0] best;
  logic                busy, done, acc, in_range;

  always_comb begin
    if (matrix_size == 0) size_n = 5'd1;
    else if (32'(matrix_size) > MAX_SIZE) size_n = 5'(MAX_SIZE);
    else size_n = {1'b0, matrix_size};
  end

  assign in_stall = busy || out_valid;
  assign acc = in_valid && !in_stall;
  assign in_range = (32'(row) < MAX_SIZE) && (32'(column) < MAX_SIZE);

  always_comb begin
    cmd = cmd_c;
    cmd.load_wr = acc && in_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= 4'd1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) matrix_size <= cfg_wdata;
      if (done) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) best_total <= 19'(best);
  end

  abb_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
    .clk(clk), .rst(rst), .in_go(acc && last), .size_n(size_n), .sts(sts),
    .chosen(chosen), .cmd(cmd_c), .rd_row(rd_row), .rd_col(rd_col), .col(col),
    .lvl(lvl), .busy(busy), .done(done)
  );

  abb_datapath #(.MAX_SIZE(MAX_SIZE), .COST_BITS(COST_BITS)) u_dp (
    .clk(clk), .cmd(cmd), .sts(sts),
    .wr_row(IDX_BITS'(row)), .wr_col(IDX_BITS'(column)),
    .wr_cost(COST_BITS'(cost)), .rd_row(rd_row), .rd_col(rd_col), .col(col),
    .lvl(lvl), .chosen(chosen), .best(best)
  );
endmodule

// File: rtl/abb_checker.sv
module abb_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic last,
  input logic out_valid,
  input logic out_stall,
  input logic [18:0] best_total
);
  ap_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(best_total))
    else $error("result dropped under stall");
  ap_block: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
  ap_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last |=> in_stall)
    else $error("search did not start");
endmodule

bind assignment_branch_and_bound_core abb_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .last(last),
  .out_valid(out_valid), .out_stall(out_stall), .best_total(best_total)
);
